// File: design/amcp_pkg.sv
// ----------------------------------------------------------------------------
// amcp_pkg
// Shared types and constants of the ASCII motion command parser.
// ----------------------------------------------------------------------------
package amcp_pkg;

	// Number of leading frame bytes that commands ever look at.
	localparam int FRAME_HEAD = 10;

	// Framing and command characters.
	localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
	localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
	localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CH_POS   = 8'h41;  // 'A', positive sign
	localparam logic [7:0] CH_MOVE  = 8'h4D;  // 'M'
	localparam logic [7:0] CH_ROT   = 8'h52;  // 'R'
	localparam logic [7:0] CH_VER   = 8'h56;  // 'V'

	// UART indexes with a fixed role.
	localparam logic [1:0] CTRL_PORT = 2'd1;
	localparam logic [1:0] ECHO_PORT = 2'd2;

	// Wheel gain 187.833 / 0.891749586 / 1000 in Q16.
	localparam logic signed [14:0] W_GAIN_Q16 = 15'sd13804;

	typedef enum logic [1:0] {
		JOB_MOVE,
		JOB_ROT,
		JOB_VER,
		JOB_ECHO
	} job_kind_t;

	typedef enum logic {
		KIND_SPEED = 1'b0,
		KIND_REPLY = 1'b1
	} res_kind_t;

	typedef logic [FRAME_HEAD-1:0][7:0] frame_head_t;

	// A finished frame that gives results, with a copy of its head bytes.
	typedef struct packed {
		job_kind_t   kind;
		frame_head_t head;
	} frame_job_t;

	// A frame after the arithmetic: speeds or the Q16 wheel term, and echo bytes.
	typedef struct packed {
		job_kind_t          kind;
		logic signed [15:0] val_a;
		logic signed [15:0] val_b;
		logic signed [33:0] term;
		logic [7:0][7:0]    echo;
	} calc_job_t;

endpackage

// File: design/amcp_in_if.sv
// ----------------------------------------------------------------------------
// amcp_in_if
// Received byte channel: UART index and raw byte, valid/ready handshake.
// ----------------------------------------------------------------------------
interface amcp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] port;
	logic [7:0] data_byte;

	modport source (output valid, output port, output data_byte, input ready);
	modport sink   (input valid, input port, input data_byte, output ready);
endinterface

// File: design/amcp_out_if.sv
// ----------------------------------------------------------------------------
// amcp_out_if
// Result channel: wheel speed sets and reply bytes, valid/ready handshake.
// ----------------------------------------------------------------------------
interface amcp_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] speed_1;
	logic signed [15:0] speed_2;
	logic signed [15:0] speed_3;
	logic signed [15:0] speed_4;
	logic [7:0]         reply_byte;
	logic [1:0]         reply_port;
	logic               last;

	modport source (output valid, output kind, output speed_1, output speed_2,
		output speed_3, output speed_4, output reply_byte, output reply_port,
		output last, input ready);
	modport sink (input valid, input kind, input speed_1, input speed_2,
		input speed_3, input speed_4, input reply_byte, input reply_port,
		input last, output ready);
endinterface

// File: design/ascii_motion_command_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_motion_command_parser_unit
// Frames bytes from up to three UARTs and turns '>' frame ends into wheel
// speed sets or reply byte runs.
// ----------------------------------------------------------------------------
// Path: a frame end's '>' item passes the capture, decode and multiply stages
//   and then the result register before its first result is valid.
// Throughput: one item per cycle; a reply run of three or eleven bytes holds
//   the result register to its end; input stalls once the stages behind fill.
// Reset: frame lengths and stored head bytes clear to zero, no items in flight.
// ----------------------------------------------------------------------------
module ascii_motion_command_parser_unit #(
	parameter int BUF_DEPTH = 128,
	parameter int NUM_PORTS = 3
) (
	input logic        clk,
	input logic        arst_n,
	amcp_in_if.sink    rx,
	amcp_out_if.source res
);
	import amcp_pkg::*;

	logic       s1_valid;
	logic       s1_ready;
	frame_job_t s1_job;
	logic       s3_valid;
	logic       s3_ready;
	calc_job_t  s3_job;

	amcp_framer #(
		.BUF_DEPTH(BUF_DEPTH),
		.NUM_PORTS(NUM_PORTS)
	) u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.s1_valid(s1_valid),
		.s1_ready(s1_ready),
		.s1_job  (s1_job)
	);

	amcp_calc u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1_valid(s1_valid),
		.s1_ready(s1_ready),
		.s1_job  (s1_job),
		.s3_valid(s3_valid),
		.s3_ready(s3_ready),
		.s3_job  (s3_job)
	);

	amcp_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.s3_valid(s3_valid),
		.s3_ready(s3_ready),
		.s3_job  (s3_job),
		.res     (res)
	);

endmodule

// File: design/amcp_framer.sv
// ----------------------------------------------------------------------------
// amcp_framer
// Per-port framing: frame lengths, stored head bytes and frame-end capture.
// ----------------------------------------------------------------------------
module amcp_framer #(
	parameter int BUF_DEPTH = 128,
	parameter int NUM_PORTS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	amcp_in_if.sink             rx,
	output logic                s1_valid,
	input  logic                s1_ready,
	output amcp_pkg::frame_job_t s1_job
);
	import amcp_pkg::*;

	localparam int LEN_W = $clog2(BUF_DEPTH);

	// Only the head bytes are ever read, so positions beyond them are not kept.
	frame_head_t      store_q [NUM_PORTS];
	logic [LEN_W-1:0] len_q   [NUM_PORTS];

	logic        s1_valid_q;
	frame_job_t  s1_job_q;

	logic        acc;
	logic        port_hit;
	frame_head_t row;
	logic        job_ok;
	job_kind_t   job_kind;

	assign rx.ready = !s1_valid_q || s1_ready;
	assign acc      = rx.valid && rx.ready;

	// Select the addressed port's head bytes.
	always_comb begin
		port_hit = 1'b0;
		row      = '0;
		for (int p = 0; p < NUM_PORTS; p++) begin
			if (rx.port == 2'(p)) begin
				port_hit = 1'b1;
				row      = store_q[p];
			end
		end
	end

	// Decode the command of a frame that ends with this item.
	always_comb begin
		job_ok   = 1'b0;
		job_kind = JOB_MOVE;
		if (port_hit && rx.data_byte == CH_CLOSE) begin
			if (rx.port == CTRL_PORT) begin
				job_ok   = (row[0] == CH_VER);
				job_kind = JOB_ECHO;
			end else begin
				case (row[0])
					CH_MOVE: begin
						job_ok   = 1'b1;
						job_kind = JOB_MOVE;
					end
					CH_ROT: begin
						job_ok   = 1'b1;
						job_kind = JOB_ROT;
					end
					CH_VER: begin
						job_ok   = 1'b1;
						job_kind = JOB_VER;
					end
					default: begin
						job_ok   = 1'b0;
						job_kind = JOB_MOVE;
					end
				endcase
			end
		end
	end

	// Frame lengths and stored bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				store_q[p] <= '0;
				len_q[p]   <= '0;
			end
		end else if (acc) begin
			for (int p = 0; p < NUM_PORTS; p++) begin
				if (rx.port == 2'(p)) begin
					if (rx.data_byte == CH_OPEN) begin
						len_q[p] <= '0;
					end else if (rx.data_byte != CH_CLOSE) begin
						if (len_q[p] == LEN_W'(BUF_DEPTH - 1)) begin
							len_q[p] <= '0;
						end else begin
							len_q[p] <= len_q[p] + 1'b1;
						end
						for (int e = 0; e < FRAME_HEAD; e++) begin
							if (len_q[p] == LEN_W'(e)) begin
								store_q[p][e] <= rx.data_byte;
							end
						end
					end
				end
			end
		end
	end

	// Frame-end stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc && job_ok) begin
			s1_valid_q <= 1'b1;
		end else if (s1_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && job_ok) begin
			s1_job_q.kind <= job_kind;
			s1_job_q.head <= row;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_job   = s1_job_q;

`ifndef ASSERT_OFF
	generate
		for (genvar g = 0; g < NUM_PORTS; g++) begin : g_len_chk
			a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
				len_q[g] <= LEN_W'(BUF_DEPTH - 1))
				else $error("frame length beyond buffer depth");
		end
	endgenerate

	a_open_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rx.port == 2'd0 && rx.data_byte == CH_OPEN) |=> (len_q[0] == '0))
		else $error("frame start did not clear the length");
`endif

endmodule

// File: design/amcp_calc.sv
// ----------------------------------------------------------------------------
// amcp_calc
// Digit decoding of a frame and the wheel term multiplication, two stages.
// ----------------------------------------------------------------------------
module amcp_calc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s1_valid,
	output logic                 s1_ready,
	input  amcp_pkg::frame_job_t s1_job,
	output logic                 s3_valid,
	input  logic                 s3_ready,
	output amcp_pkg::calc_job_t  s3_job
);
	import amcp_pkg::*;

	typedef struct packed {
		job_kind_t          kind;
		logic signed [15:0] val_a;
		logic signed [18:0] val_b;
		logic [7:0][7:0]    echo;
	} dec_job_t;

	// A digit is the byte less '0', taken as signed whatever the byte is.
	function automatic logic signed [8:0] dig(input logic [7:0] b);
		return $signed({1'b0, b}) - $signed({1'b0, CH_ZERO});
	endfunction

	function automatic logic signed [15:0] three_dig(input logic [7:0] b0,
		input logic [7:0] b1, input logic [7:0] b2);
		logic signed [15:0] d0;
		logic signed [15:0] d1;
		logic signed [15:0] d2;
		d0 = 16'(dig(b0));
		d1 = 16'(dig(b1));
		d2 = 16'(dig(b2));
		return d0 * 16'sd100 + d1 * 16'sd10 + d2;
	endfunction

	function automatic logic signed [18:0] apply_sign(input logic [7:0] s,
		input logic signed [18:0] v);
		return (s == CH_POS) ? v : -v;
	endfunction

	logic      s2_valid_q;
	dec_job_t  s2_q;
	dec_job_t  s2_d;
	logic      s2_adv;

	logic      s3_valid_q;
	calc_job_t s3_q;

	logic signed [18:0] vx_w;
	logic signed [18:0] b_w;
	logic signed [18:0] w_w;

	assign s2_adv   = !s3_valid_q || s3_ready;
	assign s1_ready = !s2_valid_q || s2_adv;

	// Signed fields of the frame head.
	always_comb begin
		vx_w = apply_sign(s1_job.head[1], 19'(three_dig(s1_job.head[2], s1_job.head[3],
			s1_job.head[4])));
		b_w  = apply_sign(s1_job.head[5], 19'(three_dig(s1_job.head[6], s1_job.head[7],
			s1_job.head[8])));
		w_w  = apply_sign(s1_job.head[5], 19'(dig(s1_job.head[6])) * 19'sd1000
			+ 19'(three_dig(s1_job.head[7], s1_job.head[8], s1_job.head[9])));
		s2_d.kind  = s1_job.kind;
		s2_d.val_a = vx_w[15:0];
		s2_d.val_b = (s1_job.kind == JOB_ROT) ? w_w : b_w;
		s2_d.echo  = s1_job.head[8:1];
	end

	// Decode stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_ready) begin
			s2_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			s2_q <= s2_d;
		end
	end

	// Multiply stage: angular speed times the wheel gain in Q16.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (s2_adv) begin
			s3_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_valid_q && s2_adv) begin
			s3_q.kind  <= s2_q.kind;
			s3_q.val_a <= s2_q.val_a;
			s3_q.val_b <= s2_q.val_b[15:0];
			s3_q.term  <= 34'(s2_q.val_b) * 34'(W_GAIN_Q16);
			s3_q.echo  <= s2_q.echo;
		end
	end

	assign s3_valid = s3_valid_q;
	assign s3_job   = s3_q;

endmodule

// File: design/amcp_emitter.sv
// ----------------------------------------------------------------------------
// amcp_emitter
// Final speed sums and saturation, reply byte sequencing, result register.
// ----------------------------------------------------------------------------
module amcp_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s3_valid,
	output logic                s3_ready,
	input  amcp_pkg::calc_job_t s3_job,
	amcp_out_if.source          res
);
	import amcp_pkg::*;

	localparam int          ECHO_LEN = 11;
	localparam int          VER_LEN  = 3;
	localparam int          IDX_W    = $clog2(ECHO_LEN);

	// Truncate a Q16 value toward zero and saturate to 16 bits.
	function automatic logic signed [15:0] sat_q16(input logic signed [34:0] s);
		logic signed [18:0] q;
		q = s[34:16];
		if (s[34] && (s[15:0] != 16'h0000)) begin
			q = q + 19'sd1;
		end
		if (q > 19'sd32767) begin
			return 16'sh7FFF;
		end else if (q < -19'sd32768) begin
			return 16'sh8000;
		end else begin
			return q[15:0];
		end
	endfunction

	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	res_kind_t          kind_q;
	logic signed [15:0] spd_q [4];
	logic [7:0]         reply_byte_q;
	logic [1:0]         reply_port_q;
	logic               last_q;

	logic               load;
	logic               last_now;
	logic signed [34:0] base;
	logic signed [34:0] sum_p;
	logic signed [34:0] sum_m;
	logic signed [15:0] spd_a;
	logic signed [15:0] spd_b;
	logic [7:0]         byte_now;
	logic [1:0]         port_now;
	logic [IDX_W-1:0]   echo_idx;

	assign load     = s3_valid && (!out_valid_q || res.ready);
	assign s3_ready = load && last_now;

	// Wheel sums for a rotation frame.
	assign base  = {{3{s3_job.val_a[15]}}, s3_job.val_a, 16'h0000};
	assign sum_p = base + 35'(s3_job.term);
	assign sum_m = base - 35'(s3_job.term);

	assign echo_idx = idx_q - IDX_W'(2);

	// Result of the current position in the job's run.
	always_comb begin
		spd_a    = '0;
		spd_b    = '0;
		byte_now = '0;
		port_now = '0;
		last_now = 1'b1;
		unique case (s3_job.kind)
			JOB_MOVE: begin
				spd_a = s3_job.val_a;
				spd_b = s3_job.val_b;
			end
			JOB_ROT: begin
				spd_a = sat_q16(sum_p);
				spd_b = sat_q16(sum_m);
			end
			JOB_VER: begin
				port_now = CTRL_PORT;
				last_now = (idx_q == IDX_W'(VER_LEN - 1));
				if (idx_q == IDX_W'(0)) begin
					byte_now = CH_OPEN;
				end else if (idx_q == IDX_W'(1)) begin
					byte_now = CH_VER;
				end else begin
					byte_now = CH_CLOSE;
				end
			end
			JOB_ECHO: begin
				port_now = ECHO_PORT;
				last_now = (idx_q == IDX_W'(ECHO_LEN - 1));
				if (idx_q == IDX_W'(0)) begin
					byte_now = CH_OPEN;
				end else if (idx_q == IDX_W'(1)) begin
					byte_now = CH_VER;
				end else if (last_now) begin
					byte_now = CH_CLOSE;
				end else begin
					byte_now = s3_job.echo[echo_idx[2:0]];
				end
			end
			default: begin
				last_now = 1'b1;
			end
		endcase
	end

	// Position within a reply run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= last_now ? '0 : idx_q + 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q       <= (s3_job.kind == JOB_MOVE || s3_job.kind == JOB_ROT)
				? KIND_SPEED : KIND_REPLY;
			spd_q[0]     <= spd_a;
			spd_q[1]     <= spd_a;
			spd_q[2]     <= spd_b;
			spd_q[3]     <= spd_b;
			reply_byte_q <= byte_now;
			reply_port_q <= port_now;
			last_q       <= last_now;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = kind_q;
	assign res.speed_1    = spd_q[0];
	assign res.speed_2    = spd_q[1];
	assign res.speed_3    = spd_q[2];
	assign res.speed_4    = spd_q[3];
	assign res.reply_byte = reply_byte_q;
	assign res.reply_port = reply_port_q;
	assign res.last       = last_q;

`ifndef ASSERT_OFF
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s3_valid |-> (idx_q == '0))
		else $error("reply position moved without a job");

	a_speed_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_SPEED) |-> last_q)
		else $error("speed result not marked last");
`endif

endmodule

// File: sim/motion_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_result_checker
// Watches the received byte channel and the result channel of the ASCII
// motion command parser. It keeps its own copy of the per-port frame stores,
// works out the speed sets and reply bytes that each accepted byte causes,
// and compares every accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module motion_result_checker #(
	parameter int BUF_DEPTH = 128,
	parameter int NUM_PORTS = 3
) (
	input logic  clk,
	input logic  arst_n,
	amcp_in_if   rx,
	amcp_out_if  res,
	output int   mismatches,
	output int   outstanding
);
	import amcp_pkg::*;

	// Wheel gain 187.833 / 0.891749586 / 1000, rounded, in Q16.
	localparam longint WHEEL_GAIN_Q16 = 13804;

	typedef struct packed {
		res_kind_t          kind;
		logic signed [15:0] speed_1;
		logic signed [15:0] speed_2;
		logic signed [15:0] speed_3;
		logic signed [15:0] speed_4;
		logic [7:0]         reply_byte;
		logic [1:0]         reply_port;
		logic               last;
	} motion_result_t;

	logic [7:0]     port_store [NUM_PORTS][BUF_DEPTH];
	int unsigned    port_len [NUM_PORTS];
	motion_result_t due_results [$];
	int             errors = 0;

	// A digit is the byte less '0', so any byte adds its own weight.
	function automatic int digit_of(logic [7:0] b);
		int v;
		v = int'(b);
		return v - int'(CH_ZERO);
	endfunction

	// Only 'A' gives a positive field; every other sign byte negates it.
	function automatic int signed_field(logic [7:0] sign_byte, int magnitude);
		return (sign_byte == CH_POS) ? magnitude : -magnitude;
	endfunction

	function automatic int three_digits(logic [1:0] p, int i);
		return digit_of(port_store[p][i]) * 100 + digit_of(port_store[p][i + 1]) * 10
			+ digit_of(port_store[p][i + 2]);
	endfunction

	// Q16 value truncated toward zero, then clamped to the int16 range.
	function automatic logic signed [15:0] q16_to_speed(longint q16);
		longint whole;
		whole = q16 / 65536;
		if (whole > 32767)
			whole = 32767;
		if (whole < -32768)
			whole = -32768;
		return 16'(whole);
	endfunction

	task automatic push_speed_set(logic signed [15:0] front, logic signed [15:0] rear);
		motion_result_t r;
		r = '0;
		r.kind    = KIND_SPEED;
		r.speed_1 = front;
		r.speed_2 = front;
		r.speed_3 = rear;
		r.speed_4 = rear;
		r.last    = 1'b1;
		due_results.push_back(r);
	endtask

	task automatic push_reply(logic [7:0] b, logic [1:0] p, logic fin);
		motion_result_t r;
		r = '0;
		r.kind       = KIND_REPLY;
		r.reply_byte = b;
		r.reply_port = p;
		r.last       = fin;
		due_results.push_back(r);
	endtask

	// Frames one received byte and queues whatever a frame end produces.
	task automatic absorb_byte(logic [1:0] p, logic [7:0] b);
		int     vx;
		int     w;
		int     a;
		int     c;
		longint term;
		longint base;
		if (p >= NUM_PORTS)
			return;
		if (b == CH_OPEN) begin
			port_len[p] = 0;
			return;
		end
		if (b != CH_CLOSE) begin
			port_store[p][port_len[p]] = b;
			port_len[p] = (port_len[p] + 1) % BUF_DEPTH;
			return;
		end
		// The controller port only answers the version request, by an echo.
		if (p == CTRL_PORT) begin
			if (port_store[p][0] == CH_VER) begin
				push_reply(CH_OPEN, ECHO_PORT, 1'b0);
				push_reply(CH_VER, ECHO_PORT, 1'b0);
				for (int i = 1; i <= 8; i++)
					push_reply(port_store[p][i], ECHO_PORT, 1'b0);
				push_reply(CH_CLOSE, ECHO_PORT, 1'b1);
			end
			return;
		end
		case (port_store[p][0])
			CH_MOVE: begin
				a = signed_field(port_store[p][1], three_digits(p, 2));
				c = signed_field(port_store[p][5], three_digits(p, 6));
				push_speed_set(16'(a), 16'(c));
			end
			CH_ROT: begin
				vx = signed_field(port_store[p][1], three_digits(p, 2));
				w = signed_field(port_store[p][5],
					digit_of(port_store[p][6]) * 1000 + three_digits(p, 7));
				term = longint'(w) * WHEEL_GAIN_Q16;
				base = longint'(vx) * 65536;
				push_speed_set(q16_to_speed(base + term), q16_to_speed(base - term));
			end
			CH_VER: begin
				push_reply(CH_OPEN, CTRL_PORT, 1'b0);
				push_reply(CH_VER, CTRL_PORT, 1'b0);
				push_reply(CH_CLOSE, CTRL_PORT, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic check_field(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want !== got) begin
			errors++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Results are checked before the byte of the same edge is framed; a frame
	// end never produces a result in the cycle it is accepted.
	always @(posedge clk or negedge arst_n) begin : watch
		motion_result_t want;
		if (!arst_n) begin
			foreach (port_store[i, j])
				port_store[i][j] = '0;
			foreach (port_len[i])
				port_len[i] = 0;
			due_results.delete();
			errors = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (due_results.size() == 0) begin
					errors++;
					$error("result with no expectation waiting: kind %0d, reply_byte %0d",
						res.kind, res.reply_byte);
				end else begin
					want = due_results.pop_front();
					check_field("kind", want.kind, res.kind);
					check_field("speed_1", want.speed_1, res.speed_1);
					check_field("speed_2", want.speed_2, res.speed_2);
					check_field("speed_3", want.speed_3, res.speed_3);
					check_field("speed_4", want.speed_4, res.speed_4);
					check_field("reply_byte", want.reply_byte, res.reply_byte);
					check_field("reply_port", want.reply_port, res.reply_port);
					check_field("last", want.last, res.last);
				end
			end
			if (rx.valid && rx.ready)
				absorb_byte(rx.port, rx.data_byte);
			mismatches <= errors;
			outstanding <= due_results.size();
		end
	end

endmodule

// File: sim/tb_ascii_motion_command_parser_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii_motion_command_parser_unit
// Feeds framed motion commands, version requests and noise into the parser
// from all UART ports, with bursty input and a stalling result side, and
// leaves the checking to the result checker beside the block.
// ----------------------------------------------------------------------------
module tb_ascii_motion_command_parser_unit;
	import amcp_pkg::*;

	localparam int BUF_DEPTH     = 128;
	localparam int NUM_PORTS     = 3;
	localparam int RANDOM_ITEMS  = 410;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 20;

	localparam logic [1:0] CMD_PORT_A = 2'd0;
	localparam logic [1:0] SPARE_PORT = 2'd3;

	typedef enum int {
		FR_MOVE,
		FR_ROT,
		FR_VER,
		FR_ODD,
		FR_SHORT,
		FR_UNFRAMED
	} frame_shape_t;

	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SLOW,
		RX_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		logic [1:0] port;
		logic [7:0] data;
	} rx_item_t;

	logic     clk;
	logic     arst_n;
	int       mismatches;
	int       outstanding;
	int       idle_cycles = 0;
	int       counted = 0;
	rx_item_t rx_items [$];

	amcp_in_if  rx_ch ();
	amcp_out_if res_ch ();

	ascii_motion_command_parser_unit #(
		.BUF_DEPTH(BUF_DEPTH),
		.NUM_PORTS(NUM_PORTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch)
	);

	motion_result_checker #(
		.BUF_DEPTH(BUF_DEPTH),
		.NUM_PORTS(NUM_PORTS)
	) result_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx_ch),
		.res        (res_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: too long without any item moving on either channel.
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** ascii_motion_command_parser_unit: FAILED **");
			$finish;
		end
	end

	// Result side stalls in stretches, each with a behaviour of its own.
	initial begin : result_stalls
		stall_mode_t mode;
		int          span;
		int          phase;
		res_ch.ready = 1'b0;
		phase = 0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(10, 150);
			repeat (span) begin
				@(negedge clk);
				phase++;
				case (mode)
					RX_FREE:  res_ch.ready <= 1'b1;
					RX_COIN:  res_ch.ready <= ($urandom_range(0, 1) == 1);
					RX_SLOW:  res_ch.ready <= ($urandom_range(0, 3) == 0);
					default:  res_ch.ready <= (phase % 5 != 4);
				endcase
			end
		end
	end

	// Any byte that leaves the framing alone.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_OPEN || b == CH_CLOSE);
		return b;
	endfunction

	// Mostly decimal digits, now and then an arbitrary byte.
	function automatic logic [7:0] digit_byte();
		if ($urandom_range(0, 7) == 0)
			return plain_byte();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] sign_byte();
		return ($urandom_range(0, 1) == 1) ? CH_POS : plain_byte();
	endfunction

	// Command ports carry most of the traffic.
	function automatic logic [1:0] pick_port();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return CMD_PORT_A;
		if (r < 8)
			return ECHO_PORT;
		return CTRL_PORT;
	endfunction

	function automatic frame_shape_t pick_shape(logic [1:0] p);
		int r;
		r = $urandom_range(0, 19);
		if (p == CTRL_PORT)
			return (r < 14) ? FR_VER : ((r < 17) ? FR_SHORT : FR_ODD);
		if (r < 7)
			return FR_MOVE;
		if (r < 14)
			return FR_ROT;
		if (r < 16)
			return FR_VER;
		if (r < 17)
			return FR_ODD;
		if (r < 19)
			return FR_SHORT;
		return FR_UNFRAMED;
	endfunction

	task automatic build_frame(input logic [1:0] p, input frame_shape_t shape,
		ref logic [7:0] fb[$]);
		logic [7:0] head;
		fb.delete();
		if (shape != FR_UNFRAMED)
			fb.push_back(CH_OPEN);
		case (shape)
			FR_MOVE: begin
				fb.push_back(CH_MOVE);
				fb.push_back(sign_byte());
				repeat (3) fb.push_back(digit_byte());
				fb.push_back(sign_byte());
				repeat (3) fb.push_back(digit_byte());
			end
			FR_ROT: begin
				fb.push_back(CH_ROT);
				fb.push_back(sign_byte());
				repeat (3) fb.push_back(digit_byte());
				fb.push_back(sign_byte());
				repeat (4) fb.push_back(digit_byte());
			end
			FR_VER: begin
				fb.push_back(CH_VER);
				// The controller's version string, zero bytes included.
				if (p == CTRL_PORT)
					repeat (8) fb.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : plain_byte());
			end
			FR_ODD: begin
				do
					head = plain_byte();
				while (head == CH_MOVE || head == CH_ROT || head == CH_VER);
				fb.push_back(head);
				repeat ($urandom_range(0, 9)) fb.push_back(plain_byte());
			end
			FR_SHORT: begin
				// A truncated body, so stale bytes of earlier frames are used.
				case ($urandom_range(0, 2))
					0:       fb.push_back(CH_MOVE);
					1:       fb.push_back(CH_ROT);
					default: fb.push_back(CH_VER);
				endcase
				repeat ($urandom_range(0, 6)) fb.push_back(digit_byte());
			end
			default: begin
				repeat ($urandom_range(0, 10)) fb.push_back(plain_byte());
			end
		endcase
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 5)) fb.push_back(plain_byte());
		fb.push_back(CH_CLOSE);
	endtask

	task automatic queue_item(logic [1:0] p, logic [7:0] b);
		rx_item_t it;
		it.port = p;
		it.data = b;
		rx_items.push_back(it);
		if (p < NUM_PORTS)
			counted++;
	endtask

	task automatic queue_text(logic [1:0] p, string s);
		for (int i = 0; i < s.len(); i++)
			queue_item(p, s[i]);
	endtask

	initial begin : stimulus
		rx_item_t   item;
		logic [7:0] frame_a [$];
		logic [7:0] frame_b [$];
		logic [1:0] pa;
		logic [1:0] pb;
		int         burst;
		int         gap;
		bit         wrapped;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.port = '0;
		rx_ch.data_byte = '0;
		wrapped = 1'b0;

		// Directed: frame ends on zeroed stores, the ignored port, every
		// command, extreme digits and a rotation built from 0xFF and 0x00 bytes.
		queue_item(CTRL_PORT, CH_CLOSE);
		queue_item(SPARE_PORT, CH_CLOSE);
		queue_text(CMD_PORT_A, "<V>");
		queue_text(ECHO_PORT, "<MA999Z000>");
		queue_text(CMD_PORT_A, "<R");
		queue_item(CMD_PORT_A, CH_POS);
		repeat (3) queue_item(CMD_PORT_A, 8'hFF);
		queue_item(CMD_PORT_A, 8'h00);
		repeat (4) queue_item(CMD_PORT_A, 8'hFF);
		queue_item(CMD_PORT_A, CH_CLOSE);
		queue_text(CTRL_PORT, "<V>");

		// Random: mostly well-formed frames, often two ports interleaved,
		// with noise on every port and one frame long enough to wrap.
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				pa = pick_port();
				frame_b.delete();
				if (!wrapped && counted >= RANDOM_ITEMS / 3) begin
					pa = CMD_PORT_A;
					build_frame(pa, FR_ROT, frame_b);
					frame_a.delete();
					frame_a.push_back(CH_OPEN);
					repeat (BUF_DEPTH) frame_a.push_back(plain_byte());
					void'(frame_b.pop_front());
					while (frame_b.size() > 0)
						frame_a.push_back(frame_b.pop_front());
					wrapped = 1'b1;
				end else begin
					build_frame(pa, pick_shape(pa), frame_a);
				end
				pb = 2'((int'(pa) + $urandom_range(1, 2)) % NUM_PORTS);
				if ($urandom_range(0, 2) == 0)
					build_frame(pb, pick_shape(pb), frame_b);
				while (frame_a.size() > 0 || frame_b.size() > 0) begin
					if (frame_b.size() == 0 || (frame_a.size() > 0 && $urandom_range(0, 1) == 0))
						queue_item(pa, frame_a.pop_front());
					else
						queue_item(pb, frame_b.pop_front());
				end
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bursts of items with random gaps, some bursts run back to back.
		while (rx_items.size() > 0) begin
			burst = $urandom_range(1, 32);
			while (burst > 0 && rx_items.size() > 0) begin
				item = rx_items.pop_front();
				@(negedge clk);
				rx_ch.valid <= 1'b1;
				rx_ch.port <= item.port;
				rx_ch.data_byte <= item.data;
				do
					@(posedge clk);
				while (rx_ch.ready !== 1'b1);
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				rx_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		rx_ch.valid <= 1'b0;

		// Drain the results still owed, then allow for any stray ones.
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** ascii_motion_command_parser_unit: PASSED **");
		else
			$display("** ascii_motion_command_parser_unit: FAILED **");
		$finish;
	end

endmodule
